// File: src/tca_pkg.sv
// Shared types and constants for the tone cadence alarm detector.
// No dependencies; used by tone_cadence_alarm_detector.
package tca_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_BIN_WIDTH  = 3'd0,
        REG_BAND_LOW   = 3'd1,
        REG_BAND_HIGH  = 3'd2,
        REG_PULSE      = 3'd3,
        REG_SPACE      = 3'd4,
        REG_HOLD       = 3'd5
    } cfg_index_t;

    localparam int CfgDataWidth = 16;

    // Register reset values
    localparam logic [9:0]  BinWidthReset  = 10'd75;
    localparam logic [15:0] BandLowReset   = 16'd3000;
    localparam logic [15:0] BandHighReset  = 16'd4000;
    localparam logic [4:0]  PulseReset     = 5'd16;
    localparam logic [5:0]  SpaceReset     = 6'd24;
    localparam logic [2:0]  HoldReset      = 3'd4;

    // Alarm totals that switch the buzzer on, and the saturation limit of the total
    localparam logic [7:0]  BuzzFirst      = 8'd1;
    localparam logic [7:0]  BuzzRepeat     = 8'd24;
    localparam logic [7:0]  AlarmMax       = 8'd255;

    // Step between LED band thresholds
    localparam int          BandStepHz     = 1000;

    typedef logic [8:0] magnitude_t;
    typedef logic [5:0] bin_index_t;

    // LED band code: 0 with no peak, 1..6 per kHz step, 7 above
    function automatic logic [2:0] band_code(input logic valid, input logic [15:0] freq);
        logic [2:0] code;
        code = 3'd7;
        for (int k = 6; k >= 1; k--) begin
            if (freq <= 16'(k * BandStepHz)) begin
                code = 3'(k);
            end
        end
        if (!valid) begin
            code = 3'd0;
        end
        return code;
    endfunction

endpackage

// File: src/tone_cadence_alarm_detector.sv
// Tone cadence alarm detector top level: peak bin search and cadence logic.
// Depends on tca_pkg for register indexes, constants and the band code function.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one FFT bin per transfer:
//   bin_real, bin_imag (signed 8 bit) and last_bin, which marks a frame's end.
//   Output channel (out_valid / out_stall) carries one result per frame, made
//   from the transfer with last_bin set; other bins produce no result.
//   Path: a bin is captured in the input register; a frame-end bin loads the
//   frame result into the output register once that register has room.
//   Throughput: one bin per cycle while in_stall is low. The peak compare and
//   frame-end update are a single short pass (one 6x10 multiply plus band
//   compares) between the input register and the result register.
//   Stall: a held result blocks the next frame-end bin, which then holds the
//   input; ordinary bins ahead of it keep flowing into the peak search.
//   Reset: asynchronous, active low; clears all counters, the peak search, the
//   valid flags of both channel registers, and loads the configuration defaults.
//   Configuration: cfg_we writes cfg_data to register cfg_index;
//   write only while the block is idle. Unknown indexes are ignored.
module tone_cadence_alarm_detector #(
    parameter int BIN_COUNT = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration
    input  logic                                 cfg_we,
    input  logic [2:0]                           cfg_index,
    input  logic [tca_pkg::CfgDataWidth-1:0]     cfg_data,
    // bin input
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [7:0]                    bin_real,
    input  logic signed [7:0]                    bin_imag,
    input  logic                                 last_bin,
    // frame result
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 peak_valid,
    output logic [5:0]                           peak_bin,
    output logic [15:0]                          peak_freq_hz,
    output logic                                 alarm_raised,
    output logic                                 buzzer_on,
    output logic [7:0]                           alarms_seen,
    output logic [2:0]                           led_code
);

    localparam tca_pkg::bin_index_t LastIdx = tca_pkg::bin_index_t'(BIN_COUNT - 1);

    // Configuration registers
    logic [9:0]  bin_width_reg;
    logic [15:0] band_low_reg;
    logic [15:0] band_high_reg;
    logic [4:0]  pulse_frames_reg;
    logic [5:0]  space_frames_reg;
    logic [2:0]  hold_frames_reg;

    // Input register
    logic        s1_valid_reg;
    logic [7:0]  s1_real_reg;
    logic [7:0]  s1_imag_reg;
    logic        s1_last_reg;

    // Peak search state
    tca_pkg::bin_index_t bin_index_reg;
    tca_pkg::magnitude_t best_mag_reg;
    tca_pkg::bin_index_t best_index_reg;
    logic                best_found_reg;

    // Cadence state
    logic [4:0]  pulse_count_reg, pulse_count_next;
    logic [5:0]  space_count_reg, space_count_next;
    logic [2:0]  hold_count_reg, hold_count_next;
    logic [7:0]  alarm_total_reg, alarm_total_next;
    logic        buzzer_reg, buzzer_next;
    logic [2:0]  led_reg, led_next;
    logic        raised_next;

    // Output register
    logic        out_valid_reg;
    logic        out_peak_valid_reg;
    logic [5:0]  out_peak_bin_reg;
    logic [15:0] out_freq_reg;
    logic        out_raised_reg;
    logic        out_buzzer_reg;
    logic [7:0]  out_alarms_reg;
    logic [2:0]  out_led_reg;

    logic        s1_adv;
    logic        s1_frame_end;
    logic        in_take;
    logic [7:0]  abs_real;
    logic [7:0]  abs_imag;
    tca_pkg::magnitude_t mag;
    logic        mag_wins;
    tca_pkg::bin_index_t cur_index;
    logic        cur_found;
    logic [15:0] freq;
    logic        in_band;

    // Handshake: a frame-end bin waits for room in the output register
    assign s1_adv       = s1_valid_reg && (!s1_last_reg || !out_valid_reg || !out_stall);
    assign s1_frame_end = s1_adv && s1_last_reg;
    assign in_stall     = s1_valid_reg && !s1_adv;
    assign in_take      = in_valid && !in_stall;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_width_reg    <= tca_pkg::BinWidthReset;
            band_low_reg     <= tca_pkg::BandLowReset;
            band_high_reg    <= tca_pkg::BandHighReset;
            pulse_frames_reg <= tca_pkg::PulseReset;
            space_frames_reg <= tca_pkg::SpaceReset;
            hold_frames_reg  <= tca_pkg::HoldReset;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tca_pkg::REG_BIN_WIDTH: bin_width_reg    <= cfg_data[9:0];
                tca_pkg::REG_BAND_LOW:  band_low_reg     <= cfg_data[15:0];
                tca_pkg::REG_BAND_HIGH: band_high_reg    <= cfg_data[15:0];
                tca_pkg::REG_PULSE:     pulse_frames_reg <= cfg_data[4:0];
                tca_pkg::REG_SPACE:     space_frames_reg <= cfg_data[5:0];
                tca_pkg::REG_HOLD:      hold_frames_reg  <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // Capture the incoming bin
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_real_reg <= bin_real;
            s1_imag_reg <= bin_imag;
            s1_last_reg <= last_bin;
        end
    end

    // Magnitude |re|+|im| and strict greater-than against the running best
    assign abs_real  = s1_real_reg[7] ? 8'(~s1_real_reg + 8'd1) : s1_real_reg;
    assign abs_imag  = s1_imag_reg[7] ? 8'(~s1_imag_reg + 8'd1) : s1_imag_reg;
    assign mag       = {1'b0, abs_real} + {1'b0, abs_imag};
    assign mag_wins  = mag > best_mag_reg;
    assign cur_index = mag_wins ? bin_index_reg : best_index_reg;
    assign cur_found = mag_wins || best_found_reg;

    // Peak frequency and band test (product fits 16 bits)
    assign freq    = cur_found ? (16'(cur_index) * 16'(bin_width_reg)) : 16'd0;
    assign in_band = cur_found && (freq > band_low_reg) && (freq <= band_high_reg);

    // Frame-end cadence update
    always_comb
    begin
        pulse_count_next = pulse_count_reg;
        space_count_next = space_count_reg;
        hold_count_next  = hold_count_reg;
        alarm_total_next = alarm_total_reg;
        buzzer_next      = buzzer_reg;
        led_next         = led_reg;
        raised_next      = 1'b0;

        if (alarm_total_reg == 8'd0)
        begin
            led_next = tca_pkg::band_code(cur_found, freq);
        end

        if (in_band)
        begin
            if (hold_count_reg == 3'd0)
            begin
                pulse_count_next = pulse_count_reg + 5'd1;
                if (pulse_count_next >= pulse_frames_reg)
                begin
                    if (alarm_total_reg != tca_pkg::AlarmMax)
                    begin
                        alarm_total_next = alarm_total_reg + 8'd1;
                    end
                    if (alarm_total_next == tca_pkg::BuzzFirst ||
                        alarm_total_next == tca_pkg::BuzzRepeat)
                    begin
                        buzzer_next = 1'b1;
                    end
                    led_next         = alarm_total_next[2:0];
                    hold_count_next  = hold_frames_reg;
                    pulse_count_next = 5'd0;
                    space_count_next = 6'd0;
                    raised_next      = 1'b1;
                end
            end
        end
        else if (pulse_count_reg != 5'd0)
        begin
            if (hold_count_reg == 3'd0)
            begin
                space_count_next = space_count_reg + 6'd1;
                if (space_count_next >= space_frames_reg)
                begin
                    pulse_count_next = 5'd0;
                    space_count_next = 6'd0;
                end
            end
        end

        // Count down the hold; the last hold frame drops the buzzer
        if (hold_count_next == 3'd1)
        begin
            buzzer_next     = 1'b0;
            hold_count_next = 3'd0;
        end
        else if (hold_count_next > 3'd1)
        begin
            hold_count_next = hold_count_next - 3'd1;
        end
    end

    // Advance the peak search and commit the cadence state at frame end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_index_reg   <= '0;
            best_mag_reg    <= '0;
            best_index_reg  <= '0;
            best_found_reg  <= 1'b0;
            pulse_count_reg <= '0;
            space_count_reg <= '0;
            hold_count_reg  <= '0;
            alarm_total_reg <= '0;
            buzzer_reg      <= 1'b0;
            led_reg         <= '0;
        end
        else if (s1_frame_end)
        begin
            bin_index_reg   <= '0;
            best_mag_reg    <= '0;
            best_index_reg  <= '0;
            best_found_reg  <= 1'b0;
            pulse_count_reg <= pulse_count_next;
            space_count_reg <= space_count_next;
            hold_count_reg  <= hold_count_next;
            alarm_total_reg <= alarm_total_next;
            buzzer_reg      <= buzzer_next;
            led_reg         <= led_next;
        end
        else if (s1_adv)
        begin
            if (mag_wins)
            begin
                best_mag_reg   <= mag;
                best_index_reg <= bin_index_reg;
                best_found_reg <= 1'b1;
            end
            if (bin_index_reg < LastIdx)
            begin
                bin_index_reg <= bin_index_reg + 6'd1;
            end
        end
    end

    // Result register: load on frame end, drop on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_frame_end)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_frame_end)
        begin
            out_peak_valid_reg <= cur_found;
            out_peak_bin_reg   <= cur_found ? cur_index : 6'd0;
            out_freq_reg       <= freq;
            out_raised_reg     <= raised_next;
            out_buzzer_reg     <= buzzer_next;
            out_alarms_reg     <= alarm_total_next;
            out_led_reg        <= led_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign peak_valid   = out_peak_valid_reg;
    assign peak_bin     = out_peak_bin_reg;
    assign peak_freq_hz = out_freq_reg;
    assign alarm_raised = out_raised_reg;
    assign buzzer_on    = out_buzzer_reg;
    assign alarms_seen  = out_alarms_reg;
    assign led_code     = out_led_reg;

    // A new result only follows a frame-end bin leaving the input register
    a_result_from_frame_end: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg && s1_last_reg)
    ) else $error("result appeared without a frame-end bin");

    // Bin index never runs past the last bin of a frame
    a_bin_index_bound: assert property (
        @(posedge clk) disable iff (!rst_n)
        bin_index_reg <= LastIdx
    ) else $error("bin index beyond frame length");

    // An alarm is only raised by a frame with a valid peak
    a_alarm_needs_peak: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_raised_reg) |-> out_peak_valid_reg
    ) else $error("alarm raised without a peak");

    // Alarm total never decreases
    a_alarm_total_monotonic: assert property (
        @(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> (alarm_total_reg >= $past(alarm_total_reg))
    ) else $error("alarm total decreased");

endmodule

// File: verif/tb.sv
// Self-checking testbench for tone_cadence_alarm_detector: a directed stimulus table, then
// random frames under three idling mixes, checked against a cycle-free frame predictor.
// Depends on tca_pkg (register indexes, reset values, constants) and the detector RTL.
`timescale 1ns / 1ps

module tb;

    localparam int BinCount     = 64;
    localparam int CycleLimit   = 400000;
    localparam int SettleCycles = 4;
    localparam int MaxReports   = 150;

    // Indexes that decode to no register
    localparam logic [2:0] RegSpareA = 3'd6;
    localparam logic [2:0] RegSpareB = 3'd7;

    typedef struct packed {
        logic        peak_valid;
        logic [5:0]  peak_bin;
        logic [15:0] peak_freq_hz;
        logic        alarm_raised;
        logic        buzzer_on;
        logic [7:0]  alarms_seen;
        logic [2:0]  led_code;
    } frame_result_t;

    typedef struct {
        int unsigned   item_no;
        frame_result_t res;
    } typed_frame_t;

    typedef enum logic {ROW_BIN, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic [2:0]         idx;
        logic [15:0]        data;
        logic signed [7:0]  re;
        logic signed [7:0]  im;
        logic               last;
        logic               typed;
        frame_result_t      res;
    } dir_row_t;

    typedef enum {FRAME_SHAPED, FRAME_NOISE, FRAME_SILENT} frame_kind_t;
    typedef enum {SET_MAX, SET_ZERO, SET_BURST, SET_RANDOM} setting_kind_t;

    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             cfg_we    = 1'b0;
    logic [2:0]                       cfg_index = 3'd0;
    logic [tca_pkg::CfgDataWidth-1:0] cfg_data  = '0;
    logic                             in_valid  = 1'b0;
    logic signed [7:0]                bin_real  = 8'sd0;
    logic signed [7:0]                bin_imag  = 8'sd0;
    logic                             last_bin  = 1'b0;
    logic                             out_stall = 1'b0;
    logic                             in_stall;
    logic                             out_valid;
    logic                             peak_valid;
    logic [5:0]                       peak_bin;
    logic [15:0]                      peak_freq_hz;
    logic                             alarm_raised;
    logic                             buzzer_on;
    logic [7:0]                       alarms_seen;
    logic [2:0]                       led_code;

    tone_cadence_alarm_detector #(
        .BIN_COUNT(BinCount)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .bin_real(bin_real),
        .bin_imag(bin_imag),
        .last_bin(last_bin),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .peak_valid(peak_valid),
        .peak_bin(peak_bin),
        .peak_freq_hz(peak_freq_hz),
        .alarm_raised(alarm_raised),
        .buzzer_on(buzzer_on),
        .alarms_seen(alarms_seen),
        .led_code(led_code)
    );

    // Predictor copy of the configuration
    logic [9:0]  bw_cfg;
    logic [15:0] lo_cfg;
    logic [15:0] hi_cfg;
    logic [4:0]  pulse_cfg;
    logic [5:0]  space_cfg;
    logic [2:0]  hold_cfg;

    // Predictor copy of the peak search and cadence state
    logic [5:0]  bin_idx;
    logic [8:0]  best_mag;
    logic [5:0]  best_idx;
    logic        best_found;
    logic [4:0]  pulse_cnt;
    logic [5:0]  space_cnt;
    logic [2:0]  hold_cnt;
    logic [7:0]  alarm_total;
    logic        buzz_lvl;
    logic [2:0]  led_lvl;

    frame_result_t expected_frames[$];
    typed_frame_t  typed_frames[$];
    int unsigned   accepted_items = 0;
    int unsigned   sent_items     = 0;
    int unsigned   cycle_count    = 0;
    int            errors         = 0;
    int            send_idle_pct  = 0;
    int            recv_idle_pct  = 0;
    logic          frame_done;
    frame_result_t frame_res;
    frame_result_t want_res;
    typed_frame_t  typed_entry;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Map a peak frequency to its kHz band code
    function automatic logic [2:0] led_band(input logic valid, input int unsigned freq);
        int unsigned code;
        if (!valid)
        begin
            return 3'd0;
        end
        code = (freq == 0) ? 1 : (freq - 1) / tca_pkg::BandStepHz + 1;
        return (code > 7) ? 3'd7 : 3'(code);
    endfunction

    // Advance the peak search by one bin; on the last bin close the frame
    task automatic track_bin(input logic signed [7:0] re, input logic signed [7:0] im,
                             input logic last, output logic done, output frame_result_t res);
        int          r_val;
        int          i_val;
        int unsigned mag;
        int unsigned freq;
        logic        valid;
        logic        in_band;
        logic        raised;
        r_val  = int'(re);
        i_val  = int'(im);
        mag    = (r_val < 0 ? -r_val : r_val) + (i_val < 0 ? -i_val : i_val);
        done   = 1'b0;
        res    = '0;
        raised = 1'b0;
        if (mag > 32'(best_mag))
        begin
            best_mag   = 9'(mag);
            best_idx   = bin_idx;
            best_found = 1'b1;
        end
        if (!last)
        begin
            // Hold the index at the top bin on an overlong frame
            if (int'(bin_idx) < BinCount - 1)
            begin
                bin_idx++;
            end
        end
        else
        begin
            valid   = best_found;
            freq    = valid ? int'(best_idx) * int'(bw_cfg) : 0;
            in_band = valid && freq > 32'(lo_cfg) && freq <= 32'(hi_cfg);
            if (alarm_total == 8'd0)
            begin
                led_lvl = led_band(valid, freq);
            end
            if (in_band)
            begin
                if (hold_cnt == 3'd0)
                begin
                    pulse_cnt = pulse_cnt + 5'd1;
                    if (pulse_cnt >= pulse_cfg)
                    begin
                        if (alarm_total < tca_pkg::AlarmMax)
                        begin
                            alarm_total++;
                        end
                        if (alarm_total == tca_pkg::BuzzFirst ||
                            alarm_total == tca_pkg::BuzzRepeat)
                        begin
                            buzz_lvl = 1'b1;
                        end
                        led_lvl   = alarm_total[2:0];
                        hold_cnt  = hold_cfg;
                        pulse_cnt = '0;
                        space_cnt = '0;
                        raised    = 1'b1;
                    end
                end
            end
            else if (pulse_cnt != 5'd0)
            begin
                // Cancel a partial pulse after enough gap frames
                if (hold_cnt == 3'd0)
                begin
                    space_cnt = space_cnt + 6'd1;
                    if (space_cnt >= space_cfg)
                    begin
                        pulse_cnt = '0;
                        space_cnt = '0;
                    end
                end
            end
            if (hold_cnt == 3'd1)
            begin
                buzz_lvl = 1'b0;
                hold_cnt = 3'd0;
            end
            else if (hold_cnt > 3'd1)
            begin
                hold_cnt--;
            end
            res.peak_valid   = valid;
            res.peak_bin     = valid ? best_idx : 6'd0;
            res.peak_freq_hz = (freq > 32'hFFFF) ? 16'hFFFF : 16'(freq);
            res.alarm_raised = raised;
            res.buzzer_on    = buzz_lvl;
            res.alarms_seen  = alarm_total;
            res.led_code     = led_lvl;
            bin_idx    = '0;
            best_mag   = '0;
            best_idx   = '0;
            best_found = 1'b0;
            done       = 1'b1;
        end
    endtask

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got)
        begin
            errors++;
            if (errors <= MaxReports)
            begin
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            end
        end
    endtask

    // Check result transfers, mirror register writes, predict on bin transfers
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            bw_cfg      = tca_pkg::BinWidthReset;
            lo_cfg      = tca_pkg::BandLowReset;
            hi_cfg      = tca_pkg::BandHighReset;
            pulse_cfg   = tca_pkg::PulseReset;
            space_cfg   = tca_pkg::SpaceReset;
            hold_cfg    = tca_pkg::HoldReset;
            bin_idx     = '0;
            best_mag    = '0;
            best_idx    = '0;
            best_found  = 1'b0;
            pulse_cnt   = '0;
            space_cnt   = '0;
            hold_cnt    = '0;
            alarm_total = '0;
            buzz_lvl    = 1'b0;
            led_lvl     = '0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_frames.size() == 0)
                begin
                    errors++;
                    if (errors <= MaxReports)
                    begin
                        $display("%0t: result with none expected, expected none actual %h",
                                 $time, {peak_valid, peak_bin, peak_freq_hz, alarm_raised,
                                         buzzer_on, alarms_seen, led_code});
                    end
                end
                else
                begin
                    want_res = expected_frames.pop_front();
                    check_field("peak_valid", 32'(want_res.peak_valid), 32'(peak_valid));
                    check_field("peak_bin", 32'(want_res.peak_bin), 32'(peak_bin));
                    check_field("peak_freq_hz", 32'(want_res.peak_freq_hz),
                                32'(peak_freq_hz));
                    check_field("alarm_raised", 32'(want_res.alarm_raised),
                                32'(alarm_raised));
                    check_field("buzzer_on", 32'(want_res.buzzer_on), 32'(buzzer_on));
                    check_field("alarms_seen", 32'(want_res.alarms_seen), 32'(alarms_seen));
                    check_field("led_code", 32'(want_res.led_code), 32'(led_code));
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    tca_pkg::REG_BIN_WIDTH: bw_cfg    = cfg_data[9:0];
                    tca_pkg::REG_BAND_LOW:  lo_cfg    = cfg_data[15:0];
                    tca_pkg::REG_BAND_HIGH: hi_cfg    = cfg_data[15:0];
                    tca_pkg::REG_PULSE:     pulse_cfg = cfg_data[4:0];
                    tca_pkg::REG_SPACE:     space_cfg = cfg_data[5:0];
                    tca_pkg::REG_HOLD:      hold_cfg  = cfg_data[2:0];
                    default:                ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                track_bin(bin_real, bin_imag, last_bin, frame_done, frame_res);
                if (frame_done)
                begin
                    // Prefer a hand-written expectation tagged to this transfer
                    if (typed_frames.size() != 0 && typed_frames[0].item_no == accepted_items)
                    begin
                        typed_entry = typed_frames.pop_front();
                        frame_res   = typed_entry.res;
                    end
                    expected_frames.push_back(frame_res);
                end
                accepted_items++;
            end
        end
    end

    // Receiver back-pressure
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Run-length guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic dir_row_t cfg_row(input logic [2:0] idx, input logic [15:0] data);
        dir_row_t row;
        row      = '0;
        row.kind = ROW_CFG;
        row.idx  = idx;
        row.data = data;
        return row;
    endfunction

    function automatic dir_row_t bin_row(input logic signed [7:0] re, input logic signed [7:0] im,
                                         input logic last, input logic typed,
                                         input frame_result_t res);
        dir_row_t row;
        row       = '0;
        row.kind  = ROW_BIN;
        row.re    = re;
        row.im    = im;
        row.last  = last;
        row.typed = typed;
        row.res   = res;
        return row;
    endfunction

    // Component of a dominant bin: magnitude 64..128, random sign (128 is always negative)
    function automatic logic signed [7:0] strong_part();
        int v;
        v = $urandom_range(64, 128);
        if (v == 128 || $urandom_range(0, 1) == 1)
        begin
            return 8'(-v);
        end
        return 8'(v);
    endfunction

    // Present one bin and hold it until the transfer
    task automatic send_bin(input logic signed [7:0] re, input logic signed [7:0] im,
                            input logic last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        bin_real <= re;
        bin_imag <= im;
        last_bin <= last;
        do
            @(posedge clk);
        while (in_stall);
        sent_items++;
    endtask

    // Drop valid and wait for every pending result plus the pipeline tail
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_frames.size() != 0 || typed_frames.size() != 0);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Narrow registers sometimes get junk above their width
    function automatic logic [15:0] with_junk(input int unsigned value, input int width);
        logic [15:0] keep;
        keep = 16'((32'd1 << width) - 1);
        if ($urandom_range(0, 3) == 0)
        begin
            return (16'(value) & keep) | (16'($urandom) & ~keep);
        end
        return 16'(value) & keep;
    endfunction

    // Pick and write a full register setting; return the bin that the band targets
    task automatic apply_setting(input setting_kind_t kind, output int tgt);
        int unsigned bw_val;
        int unsigned f;
        int unsigned lo_val;
        int unsigned hi_val;
        int unsigned pulse_val;
        int unsigned space_val;
        int unsigned hold_val;
        int unsigned r;
        case (kind)
            SET_MAX:
            begin
                pulse_val = 31;
                space_val = 63;
                hold_val  = 7;
            end
            SET_ZERO:
            begin
                pulse_val = 0;
                space_val = 0;
                hold_val  = 0;
            end
            SET_BURST:
            begin
                pulse_val = 1;
                space_val = 1;
                hold_val  = 1;
            end
            default:
            begin
                pulse_val = $urandom_range(0, 31);
                space_val = $urandom_range(0, 63);
                hold_val  = $urandom_range(0, 7);
            end
        endcase
        if (kind == SET_BURST)
        begin
            tgt = 1;
        end
        else
        begin
            tgt = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 63) : $urandom_range(1, 6);
        end
        r = $urandom_range(0, 5);
        bw_val = (r == 0) ? 1 : (r == 1) ? 1023 : $urandom_range(1, 1023);
        f = tgt * bw_val;
        r = (kind == SET_BURST) ? 7 : $urandom_range(0, 7);
        case (r)
            0:
            begin
                lo_val = 0;
                hi_val = 65535;
            end
            1:
            begin
                // Target frequency sits on the inclusive upper edge
                lo_val = f - 1;
                hi_val = f;
            end
            2:
            begin
                // Target frequency sits on the exclusive lower edge
                lo_val = f;
                hi_val = f + bw_val;
            end
            3:
            begin
                lo_val = 65535;
                hi_val = 0;
            end
            default:
            begin
                lo_val = f - 1 - $urandom_range(0, bw_val - 1);
                hi_val = f + $urandom_range(0, bw_val);
            end
        endcase
        if (hi_val > 65535)
        begin
            hi_val = 65535;
        end
        if ($urandom_range(0, 3) == 0)
        begin
            write_reg(($urandom_range(0, 1) == 1) ? RegSpareA : RegSpareB, 16'($urandom));
        end
        write_reg(tca_pkg::REG_BIN_WIDTH, with_junk(bw_val, 10));
        write_reg(tca_pkg::REG_BAND_LOW, 16'(lo_val));
        write_reg(tca_pkg::REG_BAND_HIGH, 16'(hi_val));
        write_reg(tca_pkg::REG_PULSE, with_junk(pulse_val, 5));
        write_reg(tca_pkg::REG_SPACE, with_junk(space_val, 6));
        write_reg(tca_pkg::REG_HOLD, with_junk(hold_val, 3));
        cfg_we <= 1'b0;
    endtask

    task automatic send_frame(input int len, input int peak, input frame_kind_t fk);
        logic signed [7:0] re;
        logic signed [7:0] im;
        for (int k = 0; k < len; k++)
        begin
            case (fk)
                FRAME_SILENT:
                begin
                    re = 8'sd0;
                    im = 8'sd0;
                end
                FRAME_NOISE:
                begin
                    re = 8'($urandom);
                    im = 8'($urandom);
                end
                default:
                begin
                    if (k == peak)
                    begin
                        re = strong_part();
                        im = strong_part();
                    end
                    else
                    begin
                        re = 8'(int'($urandom_range(0, 80)) - 40);
                        im = 8'(int'($urandom_range(0, 80)) - 40);
                    end
                end
            endcase
            send_bin(re, im, k == len - 1);
        end
    endtask

    // One setting: write registers, stream whole frames, then drain
    task automatic run_setting(input setting_kind_t kind, input int budget);
        int          tgt;
        int          len;
        int          peak;
        int          tone_pct;
        int unsigned start;
        int unsigned r;
        frame_kind_t fk;
        apply_setting(kind, tgt);
        start    = sent_items;
        tone_pct = (kind == SET_BURST) ? 92 : 60;
        while (sent_items - start < budget)
        begin
            r = $urandom_range(0, 99);
            if (kind == SET_BURST)
            begin
                len = 2;
            end
            else if (r < 3)
            begin
                len = $urandom_range(65, 72);
            end
            else if (r < 8)
            begin
                len = $urandom_range(33, 64);
            end
            else
            begin
                len = tgt + 1 + $urandom_range(0, 3);
            end
            r    = $urandom_range(0, 99);
            fk   = FRAME_SHAPED;
            peak = tgt;
            if (r >= tone_pct && r < tone_pct + 20)
            begin
                peak = $urandom_range(0, len - 1);
            end
            else if (r >= tone_pct + 20 && r < 94)
            begin
                fk = FRAME_NOISE;
            end
            else if (r >= 94)
            begin
                fk = FRAME_SILENT;
            end
            send_frame(len, peak, fk);
        end
        settle();
    endtask

    initial
    begin
        dir_row_t rows[$];

        // Defaults after reset: silent frame, single-bin extremes, tie on the peak
        rows.push_back(bin_row(8'sd0, 8'sd0, 1'b1, 1'b1,
                               {1'b0, 6'd0, 16'd0, 1'b0, 1'b0, 8'd0, 3'd0}));
        rows.push_back(bin_row(-8'sd128, -8'sd128, 1'b1, 1'b1,
                               {1'b1, 6'd0, 16'd0, 1'b0, 1'b0, 8'd0, 3'd1}));
        rows.push_back(bin_row(8'sd0, 8'sd0, 1'b0, 1'b0, '0));
        rows.push_back(bin_row(8'sd127, -8'sd128, 1'b1, 1'b1,
                               {1'b1, 6'd1, 16'd75, 1'b0, 1'b0, 8'd0, 3'd1}));
        rows.push_back(bin_row(8'sd3, 8'sd4, 1'b0, 1'b0, '0));
        rows.push_back(bin_row(-8'sd10, 8'sd0, 1'b0, 1'b0, '0));
        rows.push_back(bin_row(8'sd0, 8'sd10, 1'b1, 1'b1,
                               {1'b1, 6'd1, 16'd75, 1'b0, 1'b0, 8'd0, 3'd1}));
        // Widest bin, open band, zero thresholds and zero hold through masked writes
        rows.push_back(cfg_row(tca_pkg::REG_BIN_WIDTH, 16'hFFFF));
        rows.push_back(cfg_row(tca_pkg::REG_BAND_LOW, 16'd0));
        rows.push_back(cfg_row(tca_pkg::REG_BAND_HIGH, 16'hFFFF));
        rows.push_back(cfg_row(tca_pkg::REG_PULSE, 16'hFFE0));
        rows.push_back(cfg_row(tca_pkg::REG_SPACE, 16'hFFC0));
        rows.push_back(cfg_row(tca_pkg::REG_HOLD, 16'h0008));
        rows.push_back(cfg_row(RegSpareA, 16'hFFFF));
        rows.push_back(cfg_row(RegSpareB, 16'h0000));
        rows.push_back(bin_row(8'sd0, 8'sd0, 1'b0, 1'b0, '0));
        rows.push_back(bin_row(8'sd1, 8'sd0, 1'b1, 1'b0, '0));
        rows.push_back(bin_row(8'sd0, 8'sd0, 1'b1, 1'b0, '0));
        // Narrowest bin, empty band, longest thresholds
        rows.push_back(cfg_row(tca_pkg::REG_BIN_WIDTH, 16'd1));
        rows.push_back(cfg_row(tca_pkg::REG_BAND_LOW, 16'hFFFF));
        rows.push_back(cfg_row(tca_pkg::REG_PULSE, 16'd31));
        rows.push_back(cfg_row(tca_pkg::REG_SPACE, 16'd63));
        rows.push_back(cfg_row(tca_pkg::REG_HOLD, 16'd7));
        rows.push_back(bin_row(8'sd1, 8'sd1, 1'b0, 1'b0, '0));
        rows.push_back(bin_row(-8'sd1, 8'sd0, 1'b0, 1'b0, '0));
        rows.push_back(bin_row(8'sd127, 8'sd127, 1'b1, 1'b0, '0));
        // Band on bin one, single-frame pulse, long hold
        rows.push_back(cfg_row(tca_pkg::REG_BAND_LOW, 16'd0));
        rows.push_back(cfg_row(tca_pkg::REG_BAND_HIGH, 16'd1));
        rows.push_back(cfg_row(tca_pkg::REG_PULSE, 16'd1));
        rows.push_back(cfg_row(tca_pkg::REG_SPACE, 16'd1));
        rows.push_back(bin_row(8'sd0, 8'sd0, 1'b0, 1'b0, '0));
        rows.push_back(bin_row(8'sd0, -8'sd1, 1'b1, 1'b0, '0));
        rows.push_back(bin_row(8'sd0, 8'sd0, 1'b0, 1'b0, '0));
        rows.push_back(bin_row(8'sd0, -8'sd1, 1'b1, 1'b0, '0));
        rows.push_back(bin_row(8'sd3, 8'sd3, 1'b1, 1'b0, '0));

        // Hold reset, then release it on a rising edge
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 13;
        recv_idle_pct = 50;

        // Walk the directed table
        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_CFG)
            begin
                if (i > 0 && rows[i - 1].kind == ROW_BIN)
                begin
                    settle();
                end
                write_reg(rows[i].idx, rows[i].data);
                if (i + 1 >= rows.size() || rows[i + 1].kind != ROW_CFG)
                begin
                    cfg_we <= 1'b0;
                end
            end
            else
            begin
                if (rows[i].typed)
                begin
                    typed_entry.item_no = sent_items;
                    typed_entry.res     = rows[i].res;
                    typed_frames.push_back(typed_entry);
                end
                send_bin(rows[i].re, rows[i].im, rows[i].last);
            end
        end
        settle();

        // Random frames: sender idles lightly, receiver heavily
        run_setting(SET_MAX, 100);
        run_setting(SET_RANDOM, 100);
        run_setting(SET_RANDOM, 100);

        // Swap the idling mix
        send_idle_pct = 50;
        recv_idle_pct = 13;
        run_setting(SET_ZERO, 100);
        run_setting(SET_RANDOM, 100);
        run_setting(SET_RANDOM, 100);

        // Full rate on both sides; the burst setting drives the alarm count to saturation
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_setting(SET_BURST, 600);
        run_setting(SET_RANDOM, 150);

        repeat (SettleCycles) @(posedge clk);
        if (errors == 0 && expected_frames.size() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
src/tca_pkg.sv
src/tone_cadence_alarm_detector.sv
verif/tb.sv
